@@ rtl/pvh_pkg.sv @@
// ----------------------------------------------------------------------------
// pvh_pkg
// Shared constants, types and helpers for the polygon vertex/edge hit tester.
// ----------------------------------------------------------------------------
package pvh_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;

  localparam int AW      = $clog2(MAX_VERTICES);
  localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W   = 6;
  localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int VW      = 2 * COORD_BITS;
  localparam int SENSE_W = 12;
  localparam int SQ_W    = 2 * SENSE_W;
  localparam int CFG_AW  = 3;

  localparam int FRAC_BITS   = 16;
  localparam int DEGEN_LIMIT = 16;

  // edge datapath widths
  localparam int DW     = COORD_BITS + 1;          // coordinate difference
  localparam int MA_W   = 2 * DW;                  // multiplier operand A
  localparam int MB_W   = DW + 1;                  // multiplier operand B
  localparam int PW     = MA_W + MB_W;             // product
  localparam int CRM_W  = 2 * DW - 1;              // |cross|, |edge|^2
  localparam int WIDE_W = 2 * CRM_W + 1;           // cross^2, |edge|^2 * r^2
  localparam int REM_W  = 2 * DW + 1;              // divider remainder
  localparam int Q_W    = FRAC_BITS + 1;           // foot ratio magnitude
  localparam int ERR_W  = DW + FRAC_BITS + 3;      // foot error magnitude

  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_APPEND  = 2'd1;
  localparam logic [1:0] MODE_REPLACE = 2'd2;
  localparam logic [1:0] MODE_QUERY   = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_RANGE    = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_DISABLED = 2'd3;

  localparam logic REG_SENSE  = 1'b0;
  localparam logic REG_ENABLE = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DW-1:0]         diff_t;

  typedef struct packed {
    logic [SENSE_W-1:0] sense;
    logic [SQ_W-1:0]    sense_sq;
    logic               enable;
  } cfg_t;

  typedef struct packed {
    logic done;
    logic hit;
  } eu_res_t;

  function automatic diff_t sdiff(input coord_t a, input coord_t b);
    return DW'(a) - DW'(b);
  endfunction

  function automatic logic [DW-1:0] mag_d(input diff_t v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

endpackage

@@ rtl/pvh_in_if.sv @@
// ----------------------------------------------------------------------------
// pvh_in_if
// Input transaction channel: opcode, point and vertex index.
// ----------------------------------------------------------------------------
interface pvh_in_if import pvh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  coord_t           px;
  coord_t           py;
  logic [IDX_W-1:0] point_index;

  modport source (output valid, mode, px, py, point_index, input ready);
  modport sink   (input valid, mode, px, py, point_index, output ready);
endinterface

@@ rtl/pvh_out_if.sv @@
// ----------------------------------------------------------------------------
// pvh_out_if
// Result transaction channel.
// ----------------------------------------------------------------------------
interface pvh_out_if import pvh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic             vertex_hit;
  logic [IDX_W-1:0] vertex_index;
  logic             edge_hit;
  logic [6:0]       edge_index;
  logic [6:0]       vertex_count;

  modport source (output valid, status, vertex_hit, vertex_index, edge_hit, edge_index,
                  vertex_count, input ready);
  modport sink   (input valid, status, vertex_hit, vertex_index, edge_hit, edge_index,
                  vertex_count, output ready);
endinterface

@@ rtl/pvh_ram.sv @@
// ----------------------------------------------------------------------------
// pvh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pvh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/pvh_cfg.sv @@
// ----------------------------------------------------------------------------
// pvh_cfg
// APB register file: sense distance (plus its square) and enable.
// ----------------------------------------------------------------------------
module pvh_cfg import pvh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [SENSE_W-1:0] sense_r;
  logic [SQ_W-1:0]    sense_sq_r;
  logic               enable_r;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sense_r    <= SENSE_W'(80);
      sense_sq_r <= SQ_W'(6400);
      enable_r   <= 1'b1;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SENSE: begin
          sense_r    <= pwdata[SENSE_W-1:0];
          sense_sq_r <= SQ_W'(pwdata[SENSE_W-1:0] * pwdata[SENSE_W-1:0]);
        end
        REG_ENABLE: enable_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SENSE:  prdata = 32'(sense_r);
      REG_ENABLE: prdata = 32'(enable_r);
      default:    prdata = '0;
    endcase
  end

  assign cfg = '{sense: sense_r, sense_sq: sense_sq_r, enable: enable_r};

endmodule

@@ rtl/pvh_edge_unit.sv @@
// ----------------------------------------------------------------------------
// pvh_edge_unit
// Sequenced edge test on one shared multiplier: circle-segment test, then
// the foot-of-perpendicular Manhattan test with a radix-2 ratio divider.
// ----------------------------------------------------------------------------
module pvh_edge_unit import pvh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  coord_t             bx,
  input  coord_t             by,
  input  coord_t             ex,
  input  coord_t             ey,
  input  coord_t             cx,
  input  coord_t             cy,
  input  logic [SENSE_W-1:0] sense,
  input  logic [SQ_W-1:0]    sense_sq,
  output eu_res_t            res
);

  localparam logic [1:0] E_IDLE = 2'd0;
  localparam logic [1:0] E_MUL  = 2'd1;
  localparam logic [1:0] E_DIV  = 2'd2;
  localparam logic [1:0] E_FOOT = 2'd3;

  logic [1:0] st_r;
  logic [4:0] cnt_r;
  logic       done_r, hit_r, fail_r, neg_r;

  logic signed [PW-1:0] prod_r, tmp_r, sum, crv, numv, errx;
  logic [CRM_W-1:0]     crm_r, len2_r;
  logic [WIDE_W-1:0]    cr2_r, rhs;
  logic [REM_W-1:0]     rem_r, rem2, magn;
  logic [Q_W-1:0]       q_r;
  logic [ERR_W-1:0]     errm_r, errm;
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb, uv;
  logic                 degen;

  diff_t bcx, bcy, ecx, ecy, ebx, eby, cbx, cby, cex, cey, bex, bey;

  assign bcx = sdiff(bx, cx);
  assign bcy = sdiff(by, cy);
  assign ecx = sdiff(ex, cx);
  assign ecy = sdiff(ey, cy);
  assign ebx = sdiff(ex, bx);
  assign eby = sdiff(ey, by);
  assign cbx = sdiff(cx, bx);
  assign cby = sdiff(cy, by);
  assign cex = sdiff(cx, ex);
  assign cey = sdiff(cy, ey);
  assign bex = sdiff(bx, ex);
  assign bey = sdiff(by, ey);

  assign degen = (mag_d(bex) < DW'(DEGEN_LIMIT)) && (mag_d(bey) < DW'(DEGEN_LIMIT));
  assign uv    = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  assign sum  = tmp_r + prod_r;
  assign crv  = tmp_r - prod_r;
  assign numv = sum;
  assign magn = numv[PW-1] ? REM_W'(-numv) : REM_W'(numv);
  assign rem2 = {rem_r[REM_W-2:0], 1'b0};
  assign rhs  = WIDE_W'($unsigned(tmp_r)) + (WIDE_W'($unsigned(prod_r)) << DW);

  // foot error: (c - b) * 2^16 - u * d, one axis per cycle
  always_comb begin
    if (cnt_r == 5'd2) begin
      errx = (PW'(cbx) <<< FRAC_BITS) - tmp_r;
    end else begin
      errx = (PW'(cby) <<< FRAC_BITS) - tmp_r;
    end
    errm = errx[PW-1] ? ERR_W'(-errx) : ERR_W'(errx);
  end

  // multiplier operand schedule
  always_comb begin
    ma = '0;
    mb = '0;
    if (st_r == E_MUL) begin
      case (cnt_r)
        5'd0:  begin ma = MA_W'(bcx); mb = MB_W'(bcx); end
        5'd1:  begin ma = MA_W'(bcy); mb = MB_W'(bcy); end
        5'd2:  begin ma = MA_W'(ecx); mb = MB_W'(ecx); end
        5'd3:  begin ma = MA_W'(ecy); mb = MB_W'(ecy); end
        5'd4:  begin ma = MA_W'(ebx); mb = MB_W'(cby); end
        5'd5:  begin ma = MA_W'(eby); mb = MB_W'(cbx); end
        5'd6:  begin ma = MA_W'(ebx); mb = MB_W'(ebx); end
        5'd7:  begin ma = MA_W'(eby); mb = MB_W'(eby); end
        5'd8:  begin ma = $signed({1'b0, crm_r}); mb = $signed({1'b0, crm_r[DW-1:0]}); end
        5'd9:  begin
          ma = $signed({1'b0, crm_r});
          mb = $signed(MB_W'(crm_r[CRM_W-1:DW]));
        end
        5'd10: begin ma = $signed({1'b0, len2_r}); mb = $signed({1'b0, sense_sq[DW-1:0]}); end
        5'd11: begin
          ma = $signed({1'b0, len2_r});
          mb = $signed(MB_W'(sense_sq[SQ_W-1:DW]));
        end
        5'd12: begin ma = MA_W'(cbx); mb = MB_W'(ebx); end
        5'd13: begin ma = MA_W'(cby); mb = MB_W'(eby); end
        5'd14: begin ma = MA_W'(cex); mb = MB_W'(bex); end
        5'd15: begin ma = MA_W'(cey); mb = MB_W'(bey); end
        5'd16: begin ma = MA_W'(cbx); mb = MB_W'(bex); end
        5'd17: begin ma = MA_W'(cby); mb = MB_W'(bey); end
        default: ;
      endcase
    end else if (st_r == E_FOOT) begin
      if (cnt_r == 5'd0) begin
        ma = MA_W'(bex);
        mb = uv;
      end else if (cnt_r == 5'd1) begin
        ma = MA_W'(bey);
        mb = uv;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= E_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        E_IDLE: begin
          if (go) begin
            st_r   <= E_MUL;
            cnt_r  <= '0;
            fail_r <= 1'b0;
          end
        end
        E_MUL: begin
          cnt_r <= cnt_r + 5'd1;
          case (cnt_r)
            5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd13, 5'd15, 5'd17: tmp_r <= prod_r;
            5'd2, 5'd4: begin
              // an end inside or on the circle rules the edge out
              if (sum <= $signed(PW'(sense_sq))) fail_r <= 1'b1;
            end
            5'd6: crm_r <= crv[PW-1] ? CRM_W'(-crv) : CRM_W'(crv);
            5'd8: len2_r <= CRM_W'(sum);
            5'd10: cr2_r <= rhs;
            5'd12: if (cr2_r > rhs) fail_r <= 1'b1;
            5'd14, 5'd16: if (sum[PW-1] || (sum == '0)) fail_r <= 1'b1;
            5'd18: begin
              cnt_r <= '0;
              if (fail_r) begin
                st_r   <= E_IDLE;
                done_r <= 1'b1;
                hit_r  <= 1'b0;
              end else begin
                neg_r <= numv[PW-1];
                q_r   <= '0;
                rem_r <= magn;
                if (degen) begin
                  st_r <= E_FOOT;
                end else if (magn >= REM_W'(len2_r)) begin
                  q_r  <= Q_W'(1) << FRAC_BITS;
                  st_r <= E_FOOT;
                end else begin
                  st_r <= E_DIV;
                end
              end
            end
            default: ;
          endcase
        end
        E_DIV: begin
          if (rem2 >= REM_W'(len2_r)) begin
            rem_r <= rem2 - REM_W'(len2_r);
            q_r   <= {q_r[Q_W-2:0], 1'b1};
          end else begin
            rem_r <= rem2;
            q_r   <= {q_r[Q_W-2:0], 1'b0};
          end
          if (cnt_r == 5'(FRAC_BITS - 1)) begin
            cnt_r <= '0;
            st_r  <= E_FOOT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        E_FOOT: begin
          cnt_r <= cnt_r + 5'd1;
          case (cnt_r)
            5'd1: tmp_r <= prod_r;
            5'd2: begin
              errm_r <= errm;
              tmp_r  <= prod_r;
            end
            5'd3: tmp_r <= $signed(PW'(errm));
            5'd4: begin
              hit_r  <= (ERR_W'(errm_r) + ERR_W'(tmp_r)) <=
                        (ERR_W'(sense) << FRAC_BITS);
              done_r <= 1'b1;
              st_r   <= E_IDLE;
            end
            default: ;
          endcase
        end
        default: st_r <= E_IDLE;
      endcase
    end
  end

  assign res = '{done: done_r, hit: hit_r};

endmodule

@@ rtl/polygon_vertex_edge_hit_test.sv @@
// ----------------------------------------------------------------------------
// polygon_vertex_edge_hit_test
// Polygon vertex store (one RAM, {x, y} per entry) with cursor hit test.
// ----------------------------------------------------------------------------
//  port       dir      kind           payload
//  in_item    sink     valid/ready    mode, px, py, point_index
//  out_item   source   valid/ready    status, vertex/edge hit + index, count
//  p*         slave    APB            0x0 sense_distance, 0x4 hit_test_enable
//
//  Clear, append, replace and disabled transactions pass EXEC and FIN into
//  the output register. A query scans the stored vertices (one RAM read
//  each, stops at the first hit), then edges: RAM fetches, 19 multiplier
//  steps per edge and, for edges passing the circle-segment test, the
//  divider and 5 foot steps, stopping at an edge hit. The single multiplier
//  in pvh_edge_unit and the one RAM read port set the query time. Reset
//  (rst_n low, synchronous) empties the store; RAM contents are kept but
//  never read beyond the count. in_item is taken whenever no transaction is
//  in flight; a finished result may wait in the output register meanwhile.
// ----------------------------------------------------------------------------
module polygon_vertex_edge_hit_test import pvh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  pvh_in_if.sink            in_item,
  pvh_out_if.source         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_VRD   = 4'd2;
  localparam logic [3:0] S_VCHK  = 4'd3;
  localparam logic [3:0] S_B0RD  = 4'd4;
  localparam logic [3:0] S_B0LAT = 4'd5;
  localparam logic [3:0] S_ERD   = 4'd6;
  localparam logic [3:0] S_ELAT  = 4'd7;
  localparam logic [3:0] S_EDGE  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  cfg_t    cfg;
  eu_res_t eu_res;

  logic [3:0]       st_r;
  logic [1:0]       mode_r;
  coord_t           cx_r, cy_r;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] cnt_r, vptr_r, en_r;
  coord_t           bx_r, by_r, ex_r, ey_r, fx_r, fy_r;
  logic             vhit_r, ehit_r, go_r, ov_r;
  logic [AW-1:0]    vidx_r;
  logic [CNT_W-1:0] eidx_r;
  logic [1:0]       status_r;

  // output register
  logic [1:0]       o_status_r;
  logic             o_vhit_r, o_ehit_r;
  logic [IDX_W-1:0] o_vidx_r;
  logic [6:0]       o_eidx_r, o_cnt_r;

  // RAM ports
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [VW-1:0] rdata;
  coord_t        rx, ry;
  logic          vnear, can_load;

  pvh_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  pvh_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_ram (
    .clk, .we, .waddr, .wdata({cx_r, cy_r}), .raddr, .rdata
  );

  pvh_edge_unit u_edge (
    .clk, .rst_n, .go(go_r),
    .bx(bx_r), .by(by_r), .ex(ex_r), .ey(ey_r), .cx(cx_r), .cy(cy_r),
    .sense(cfg.sense), .sense_sq(cfg.sense_sq), .res(eu_res)
  );

  assign rx = $signed(rdata[VW-1:COORD_BITS]);
  assign ry = $signed(rdata[COORD_BITS-1:0]);

  // Manhattan distance of the fetched vertex to the cursor
  assign vnear = ((DW+1)'(mag_d(sdiff(rx, cx_r))) + (DW+1)'(mag_d(sdiff(ry, cy_r))))
                 <= (DW+1)'(cfg.sense);

  assign in_item.ready = (st_r == S_IDLE);
  assign can_load      = !ov_r || out_item.ready;

  // store writes happen only in EXEC, so reads of a query never overlap them
  always_comb begin
    we    = 1'b0;
    waddr = AW'(cnt_r);
    if ((st_r == S_EXEC) && cfg.enable) begin
      if ((mode_r == MODE_APPEND) && (cnt_r < CNT_W'(MAX_VERTICES))) begin
        we = 1'b1;
      end else if ((mode_r == MODE_REPLACE) && (CMP_W'(idx_r) < CMP_W'(cnt_r))) begin
        we    = 1'b1;
        waddr = AW'(idx_r);
      end
    end
  end

  always_comb begin
    case (st_r)
      S_VRD:   raddr = AW'(vptr_r);
      S_ERD:   raddr = AW'(en_r);
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cnt_r  <= '0;
      go_r   <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      go_r <= 1'b0;
      if (ov_r && out_item.ready) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (in_item.valid) begin
            mode_r <= in_item.mode;
            cx_r   <= in_item.px;
            cy_r   <= in_item.py;
            idx_r  <= in_item.point_index;
            st_r   <= S_EXEC;
          end
        end
        S_EXEC: begin
          status_r <= STAT_OK;
          vhit_r   <= 1'b0;
          vidx_r   <= '0;
          ehit_r   <= 1'b0;
          eidx_r   <= '0;
          vptr_r   <= '0;
          st_r     <= S_FIN;
          if (!cfg.enable) begin
            status_r <= STAT_DISABLED;
          end else begin
            unique case (mode_r)
              MODE_CLEAR: cnt_r <= '0;
              MODE_APPEND: begin
                if (cnt_r < CNT_W'(MAX_VERTICES)) cnt_r <= cnt_r + CNT_W'(1);
                else status_r <= STAT_FULL;
              end
              MODE_REPLACE: begin
                if (CMP_W'(idx_r) >= CMP_W'(cnt_r)) status_r <= STAT_RANGE;
              end
              MODE_QUERY: begin
                if (cnt_r != '0) st_r <= S_VRD;
              end
              default: ;
            endcase
          end
        end
        S_VRD: st_r <= S_VCHK;
        S_VCHK: begin
          // vertex pass stops at the first hit; then the edge pass starts if at least two vertices are stored
          if (vnear) begin
            vhit_r <= 1'b1;
            vidx_r <= AW'(vptr_r);
            st_r   <= (cnt_r < CNT_W'(2)) ? S_FIN : S_B0RD;
          end else if (vptr_r + CNT_W'(1) == cnt_r) begin
            st_r <= (cnt_r < CNT_W'(2)) ? S_FIN : S_B0RD;
          end else begin
            vptr_r <= vptr_r + CNT_W'(1);
            st_r   <= S_VRD;
          end
        end
        S_B0RD: st_r <= S_B0LAT;
        S_B0LAT: begin
          bx_r <= rx;
          by_r <= ry;
          fx_r <= rx;
          fy_r <= ry;
          en_r <= CNT_W'(1);
          st_r <= S_ERD;
        end
        S_ERD: st_r <= S_ELAT;
        S_ELAT: begin
          ex_r <= rx;
          ey_r <= ry;
          go_r <= 1'b1;
          st_r <= S_EDGE;
        end
        S_EDGE: begin
          if (eu_res.done) begin
            if (eu_res.hit) begin
              ehit_r <= 1'b1;
              eidx_r <= en_r;
              st_r   <= S_FIN;
            end else if (en_r == cnt_r) begin
              st_r <= S_FIN;
            end else begin
              bx_r <= ex_r;
              by_r <= ey_r;
              en_r <= en_r + CNT_W'(1);
              if (en_r + CNT_W'(1) == cnt_r) begin
                // closing edge: end point is vertex 0, already held
                ex_r <= fx_r;
                ey_r <= fy_r;
                go_r <= 1'b1;
              end else begin
                st_r <= S_ERD;
              end
            end
          end
        end
        S_FIN: begin
          if (can_load) begin
            ov_r       <= 1'b1;
            o_status_r <= status_r;
            o_vhit_r   <= vhit_r;
            o_vidx_r   <= IDX_W'(vidx_r);
            o_ehit_r   <= ehit_r;
            o_eidx_r   <= 7'(eidx_r);
            o_cnt_r    <= 7'(cnt_r);
            st_r       <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_item.valid        = ov_r;
  assign out_item.status       = o_status_r;
  assign out_item.vertex_hit   = o_vhit_r;
  assign out_item.vertex_index = o_vidx_r;
  assign out_item.edge_hit     = o_ehit_r;
  assign out_item.edge_index   = o_eidx_r;
  assign out_item.vertex_count = o_cnt_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_item.valid && in_item.ready) |=> (st_r == S_EXEC))
    else $error("accepted transaction did not enter EXEC");

  a_count_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> ($past(st_r) == S_EXEC))
    else $error("vertex count changed outside EXEC");

  a_done_edge: assert property (@(posedge clk) disable iff (!rst_n)
    eu_res.done |-> (st_r == S_EDGE))
    else $error("edge unit finished while not awaited");

  a_edge_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (o_eidx_r <= o_cnt_r))
    else $error("edge index beyond vertex count");

endmodule
